### design/omc_pkg.sv
// omc_pkg: shared types and constants for the online mean and covariance block
// used by omc_div and online_mean_covariance; no dependencies
package omc_pkg;

  localparam int DIV_W = 56;
  localparam int DVS_W = 20;
  localparam int STEP_W = 6;
  localparam int CM_W = 56;
  localparam int VAL_W = 40;
  localparam int DEV_W = 26;
  localparam int MEAN_W = 24;

  localparam logic [7:0] OFFSET_RESET = 8'd33;
  localparam logic [19:0] CAP_RESET = 20'd100000;

  localparam logic [1:0] FN_PUSH = 2'd0;
  localparam logic [1:0] FN_MEAN = 2'd1;
  localparam logic [1:0] FN_COV = 2'd2;
  localparam logic [1:0] FN_CLEAR = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_LEN = 3'd1;
  localparam logic [2:0] ST_FEW = 3'd2;
  localparam logic [2:0] ST_CAP = 3'd3;
  localparam logic [2:0] ST_IDX = 3'd4;

  localparam logic REG_OFFSET = 1'b0;
  localparam logic REG_CAP = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PMEAN_RD,
    S_PDIV_START,
    S_PDIV,
    S_PLOOP,
    S_QMEAN_RD,
    S_QMEAN_FIN,
    S_QCOV_RD,
    S_QCOV_START,
    S_QCOV_DIV,
    S_RESULT
  } state_t;

  typedef struct packed {
    logic start;
    logic [DIV_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

### design/omc_div.sv
// omc_div: restoring unsigned divider, one quotient bit per cycle
// depends on omc_pkg for the request and response structs
module omc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  omc_pkg::div_req_t req_i,
  output omc_pkg::div_rsp_t rsp_o
);

  logic                       busy_r;
  logic                       done_r;
  logic [omc_pkg::STEP_W-1:0] cnt_r;
  logic [omc_pkg::DIV_W-1:0]  dvd_r;
  logic [omc_pkg::DVS_W-1:0]  rem_r;
  logic [omc_pkg::DVS_W-1:0]  dvs_r;
  logic [omc_pkg::DVS_W:0]    sh;
  logic                       ge;

  assign sh = {rem_r, dvd_r[omc_pkg::DIV_W-1]};
  assign ge = (sh >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (req_i.start) begin
        busy_r <= 1'b1;
        cnt_r <= req_i.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == omc_pkg::STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_i.start) begin
      dvd_r <= req_i.dividend;
      dvs_r <= req_i.divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      // remainder stays below the divisor, so its top bit drops out
      rem_r <= ge ? omc_pkg::DVS_W'(sh - {1'b0, dvs_r}) : sh[omc_pkg::DVS_W-1:0];
      dvd_r <= {dvd_r[omc_pkg::DIV_W-2:0], ge};
    end
  end

  assign rsp_o.done = done_r;
  assign rsp_o.quotient = dvd_r;

endmodule

### design/online_mean_covariance.sv
// online_mean_covariance: per-position running mean and co-moment of quality bytes
// depends on omc_pkg and omc_div
//
// input channel (in_valid/in_ready): one request per item; func selects push,
//   mean query, covariance query or clear. every request yields one result on
//   the output channel (out_valid/out_ready) with out_value and out_status.
// a push at position i reads the mean, runs a 26-step division by the read
//   count, then sweeps i+1 co-moment entries through a 3-stage read, multiply,
//   accumulate pipeline.
// a covariance query runs a 56-step division of the co-moment by read count
//   minus one.
// rejected requests (status not ok) go straight to the result state.
// reset and a clear request both run a clearing pass over the co-moment and
//   mean memories, one entry a cycle over MAX_LEN*(MAX_LEN+1)/2 entries (32896 at
//   the default), with in_ready low; configuration writes are taken any time.
// the result sits in an output register; a new request is taken while it waits,
//   and the block stalls only if a second result is ready before the first leaves.
module online_mean_covariance #(
  parameter int MAX_LEN = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [7:0]  in_quality,
  input  logic        in_last_in_read,
  input  logic [7:0]  in_row,
  input  logic [7:0]  in_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [39:0] out_value,
  output logic [2:0]  out_status,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);

  localparam int PW = $clog2(MAX_LEN + 1);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int TRI_DEPTH = MAX_LEN * (MAX_LEN + 1) / 2;
  localparam int TW = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;
  localparam int CMW = omc_pkg::CM_W;
  localparam int DW = omc_pkg::DEV_W;
  localparam int MW = omc_pkg::MEAN_W;

  // storage
  logic [MW-1:0]  mean_mem [MAX_LEN];
  logic [CMW-1:0] cm_mem [TRI_DEPTH];
  logic [DW-1:0]  dev_mem [MAX_LEN];

  logic           mean_we;
  logic [AW-1:0]  mean_waddr, mean_raddr;
  logic [MW-1:0]  mean_wdata, mean_q;
  logic           cm_we;
  logic [TW-1:0]  cm_waddr, cm_raddr;
  logic [CMW-1:0] cm_wdata, cm_q;
  logic           dev_we;
  logic [DW-1:0]  dev_wdata, dev_q;

  omc_pkg::state_t state_r, state_nxt;
  omc_pkg::div_req_t div_req;
  omc_pkg::div_rsp_t div_rsp;

  // control registers
  logic [PW-1:0]  pos_r, learned_r;
  logic [19:0]    rc_r, cap_r;
  logic [7:0]     off_r;
  logic           fault_r;
  logic           out_valid_r;
  logic [TW-1:0]  clr_cnt_r;
  logic           clr_reply_r;
  logic           iss_r, v1_r, v2_r;

  // payload registers
  logic [7:0]     q_r, row_r, col_r;
  logic [AW-1:0]  i_r, j_r;
  logic [MW-1:0]  mean_r;
  logic [DW-1:0]  e_r;
  logic [TW-1:0]  base_r, k1_r, k2_r;
  logic signed [2*DW-1:0] prod_r;
  logic [CMW-1:0] cmh_r;
  logic           neg_r;
  logic [39:0]    res_value_r, out_value_r;
  logic [2:0]     res_status_r, out_status_r;

  // request decode
  logic           in_acc;
  logic [2:0]     acc_status;
  logic           acc_go;
  logic           len_bad;
  logic [19:0]    rc_new;

  // datapath
  logic signed [DW-1:0] d_c;
  logic [DW-1:0]  dmag_c;
  logic [DW-1:0]  step_c;
  logic [DW-1:0]  mean_new_c;
  logic [DW-1:0]  e_c;
  logic [2*DW-1:0] pmag_c;
  logic [2*DW-1:0] rnd_c;
  logic [CMW:0]   add_c, sum_c;
  logic [CMW-1:0] sat_c;
  logic [CMW-1:0] cmag_c;
  logic [16:0]    qtri_c;
  logic [2*AW:0]  ptri_c;
  logic [39:0]    cov_c;
  logic [omc_pkg::DIV_W-1:0] quo;

  assign in_acc = in_valid && in_ready;
  assign in_ready = (state_r == omc_pkg::S_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign out_status = out_status_r;
  assign quo = div_rsp.quotient;

  omc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req_i (div_req),
    .rsp_o (div_rsp)
  );

  // memories, registered read
  always_ff @(posedge clk) begin
    if (mean_we) mean_mem[mean_waddr] <= mean_wdata;
    mean_q <= mean_mem[mean_raddr];
  end

  always_ff @(posedge clk) begin
    if (cm_we) cm_mem[cm_waddr] <= cm_wdata;
    cm_q <= cm_mem[cm_raddr];
  end

  always_ff @(posedge clk) begin
    if (dev_we) dev_mem[i_r] <= dev_wdata;
    dev_q <= dev_mem[j_r];
  end

  // decode of an incoming request against current state
  always_comb begin
    acc_status = omc_pkg::ST_OK;
    acc_go = 1'b0;
    rc_new = (pos_r == '0) ? rc_r + 20'd1 : rc_r;
    len_bad = (pos_r >= PW'(MAX_LEN)) || ((learned_r != '0) &&
              ((pos_r >= learned_r) || (in_last_in_read && (pos_r + 1'b1 != learned_r))));
    case (in_func)
      omc_pkg::FN_PUSH: begin
        if (fault_r) acc_status = omc_pkg::ST_LEN;
        else if ((pos_r == '0) && (rc_r >= cap_r)) acc_status = omc_pkg::ST_CAP;
        else if (len_bad) acc_status = omc_pkg::ST_LEN;
        else if (rc_new == '0) acc_status = omc_pkg::ST_CAP;
        else acc_go = 1'b1;
      end
      omc_pkg::FN_MEAN: begin
        if (fault_r) acc_status = omc_pkg::ST_LEN;
        else if ((learned_r == '0) || (rc_r == '0)) acc_status = omc_pkg::ST_FEW;
        else if (32'(in_row) >= 32'(learned_r)) acc_status = omc_pkg::ST_IDX;
        else acc_go = 1'b1;
      end
      omc_pkg::FN_COV: begin
        if (fault_r) acc_status = omc_pkg::ST_LEN;
        else if ((rc_r < 20'd2) || (learned_r == '0)) acc_status = omc_pkg::ST_FEW;
        else if ((32'(in_row) >= 32'(learned_r)) || (in_col > in_row))
          acc_status = omc_pkg::ST_IDX;
        else acc_go = 1'b1;
      end
      omc_pkg::FN_CLEAR: acc_go = 1'b1;
      default: acc_go = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      omc_pkg::S_CLEAR:
        if (clr_cnt_r == TW'(TRI_DEPTH - 1))
          state_nxt = clr_reply_r ? omc_pkg::S_RESULT : omc_pkg::S_IDLE;
      omc_pkg::S_IDLE:
        if (in_valid) begin
          if (!acc_go) state_nxt = omc_pkg::S_RESULT;
          else begin
            case (in_func)
              omc_pkg::FN_PUSH: state_nxt = omc_pkg::S_PMEAN_RD;
              omc_pkg::FN_MEAN: state_nxt = omc_pkg::S_QMEAN_RD;
              omc_pkg::FN_COV: state_nxt = omc_pkg::S_QCOV_RD;
              default: state_nxt = omc_pkg::S_CLEAR;
            endcase
          end
        end
      omc_pkg::S_PMEAN_RD: state_nxt = omc_pkg::S_PDIV_START;
      omc_pkg::S_PDIV_START: state_nxt = omc_pkg::S_PDIV;
      omc_pkg::S_PDIV: if (div_rsp.done) state_nxt = omc_pkg::S_PLOOP;
      omc_pkg::S_PLOOP: if (!iss_r && !v1_r && !v2_r) state_nxt = omc_pkg::S_RESULT;
      omc_pkg::S_QMEAN_RD: state_nxt = omc_pkg::S_QMEAN_FIN;
      omc_pkg::S_QMEAN_FIN: state_nxt = omc_pkg::S_RESULT;
      omc_pkg::S_QCOV_RD: state_nxt = omc_pkg::S_QCOV_START;
      omc_pkg::S_QCOV_START: state_nxt = omc_pkg::S_QCOV_DIV;
      omc_pkg::S_QCOV_DIV: if (div_rsp.done) state_nxt = omc_pkg::S_RESULT;
      omc_pkg::S_RESULT: if (!out_valid_r || out_ready) state_nxt = omc_pkg::S_IDLE;
      default: state_nxt = omc_pkg::S_IDLE;
    endcase
  end

  // datapath arithmetic
  always_comb begin
    d_c = $signed({2'b00, q_r, 16'h0000}) - $signed({2'b00, mean_q});
    dmag_c = d_c[DW-1] ? DW'(-d_c) : DW'(d_c);
    step_c = neg_r ? DW'(-quo[DW-1:0]) : quo[DW-1:0];
    mean_new_c = {2'b00, mean_r} + step_c;
    e_c = {2'b00, q_r, 16'h0000} - {2'b00, mean_new_c[MW-1:0]};
    pmag_c = prod_r[2*DW-1] ? (2*DW)'(-prod_r) : (2*DW)'(prod_r);
    rnd_c = (pmag_c + (2*DW)'(32768)) >> 16;
    add_c = prod_r[2*DW-1] ? (CMW+1)'(-rnd_c) : (CMW+1)'(rnd_c);
    sum_c = {cmh_r[CMW-1], cmh_r} + add_c;
    if (sum_c[CMW] != sum_c[CMW-1]) sat_c = sum_c[CMW] ? {1'b1, {(CMW-1){1'b0}}}
                                                        : {1'b0, {(CMW-1){1'b1}}};
    else sat_c = sum_c[CMW-1:0];
    cmag_c = cm_q[CMW-1] ? CMW'(-cm_q) : cm_q;
    qtri_c = 17'((18'(row_r) * (18'(row_r) + 18'd1)) >> 1) + 17'(col_r);
    ptri_c = (2*AW+1)'(((2*AW+2)'(i_r) * ((2*AW+2)'(i_r) + 1'b1)) >> 1);
    if (neg_r) cov_c = (quo > 56'd549755813888) ? 40'h80_0000_0000 : 40'(-quo);
    else cov_c = (quo > 56'd549755813887) ? 40'h7F_FFFF_FFFF : 40'(quo);
  end

  // memory and divider controls
  always_comb begin
    mean_we = 1'b0;
    mean_waddr = i_r;
    mean_wdata = mean_new_c[MW-1:0];
    mean_raddr = (state_r == omc_pkg::S_QMEAN_RD) ? AW'(row_r) : i_r;
    cm_we = 1'b0;
    cm_waddr = k2_r;
    cm_wdata = sat_c;
    cm_raddr = (state_r == omc_pkg::S_QCOV_RD) ? TW'(qtri_c) : TW'(base_r + TW'(j_r));
    dev_we = 1'b0;
    dev_wdata = DW'(d_c);
    div_req.start = 1'b0;
    div_req.dividend = {dmag_c, {(omc_pkg::DIV_W-DW){1'b0}}};
    div_req.divisor = rc_r;
    div_req.steps = omc_pkg::STEP_W'(DW);
    case (state_r)
      omc_pkg::S_CLEAR: begin
        cm_we = 1'b1;
        cm_waddr = clr_cnt_r;
        cm_wdata = '0;
        mean_we = (32'(clr_cnt_r) < MAX_LEN);
        mean_waddr = AW'(clr_cnt_r);
        mean_wdata = '0;
      end
      omc_pkg::S_PDIV_START: begin
        dev_we = 1'b1;
        div_req.start = 1'b1;
      end
      omc_pkg::S_PDIV: mean_we = div_rsp.done;
      omc_pkg::S_PLOOP: cm_we = v2_r;
      omc_pkg::S_QCOV_START: begin
        div_req.start = 1'b1;
        div_req.dividend = cmag_c;
        div_req.divisor = rc_r - 20'd1;
        div_req.steps = omc_pkg::STEP_W'(omc_pkg::DIV_W);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= omc_pkg::S_CLEAR;
      pos_r <= '0;
      learned_r <= '0;
      rc_r <= '0;
      fault_r <= 1'b0;
      off_r <= omc_pkg::OFFSET_RESET;
      cap_r <= omc_pkg::CAP_RESET;
      out_valid_r <= 1'b0;
      clr_cnt_r <= '0;
      clr_reply_r <= 1'b0;
      iss_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        if (cfg_index == omc_pkg::REG_OFFSET) off_r <= cfg_wdata[7:0];
        else cap_r <= cfg_wdata;
      end
      if ((state_r == omc_pkg::S_RESULT) && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (state_r == omc_pkg::S_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;
      if (in_acc) begin
        case (in_func)
          omc_pkg::FN_PUSH: begin
            if (!fault_r && !((pos_r == '0) && (rc_r >= cap_r))) begin
              if (len_bad) fault_r <= 1'b1;
              else begin
                rc_r <= rc_new;
                if (rc_new != '0) begin
                  if (in_last_in_read) begin
                    if (learned_r == '0) learned_r <= pos_r + 1'b1;
                    pos_r <= '0;
                  end else begin
                    pos_r <= pos_r + 1'b1;
                  end
                end
              end
            end
          end
          omc_pkg::FN_CLEAR: begin
            pos_r <= '0;
            learned_r <= '0;
            rc_r <= '0;
            fault_r <= 1'b0;
            clr_cnt_r <= '0;
            clr_reply_r <= 1'b1;
          end
          default: ;
        endcase
      end
      // co-moment sweep: issue, multiply, accumulate
      v1_r <= (state_r == omc_pkg::S_PLOOP) && iss_r;
      v2_r <= v1_r;
      if ((state_r == omc_pkg::S_PDIV) && div_rsp.done) iss_r <= 1'b1;
      else if ((state_r == omc_pkg::S_PLOOP) && iss_r && (j_r == i_r)) iss_r <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      q_r <= in_quality;
      row_r <= in_row;
      col_r <= in_col;
      i_r <= AW'(pos_r);
      res_status_r <= acc_status;
      res_value_r <= '0;
    end
    if (state_r == omc_pkg::S_PDIV_START) begin
      mean_r <= mean_q;
      neg_r <= d_c[DW-1];
      base_r <= TW'(ptri_c);
    end
    if ((state_r == omc_pkg::S_PDIV) && div_rsp.done) begin
      e_r <= e_c;
      j_r <= '0;
    end
    if ((state_r == omc_pkg::S_PLOOP) && iss_r) begin
      j_r <= j_r + 1'b1;
      k1_r <= cm_raddr;
    end
    prod_r <= $signed(dev_q) * $signed(e_r);
    cmh_r <= cm_q;
    k2_r <= k1_r;
    if (state_r == omc_pkg::S_QMEAN_FIN)
      res_value_r <= {16'h0000, mean_q} - {16'h0000, off_r, 16'h0000};
    if (state_r == omc_pkg::S_QCOV_START) neg_r <= cm_q[CMW-1];
    if ((state_r == omc_pkg::S_QCOV_DIV) && div_rsp.done) res_value_r <= cov_c;
    if ((state_r == omc_pkg::S_RESULT) && (!out_valid_r || out_ready)) begin
      out_value_r <= res_value_r;
      out_status_r <= res_status_r;
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == omc_pkg::S_IDLE) |-> (!cm_we && !mean_we && !dev_we))
    else $error("store written while idle");
  a_div_start_once: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |=> !div_req.start)
    else $error("divider restarted back to back");
  a_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == omc_pkg::S_PLOOP) && iss_r) |-> (j_r <= i_r))
    else $error("co-moment sweep past current position");
  a_fault_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    fault_r |-> !dev_we)
    else $error("push processed under length fault");
`endif

endmodule

### tb/sv/online_mean_covariance_tb.sv
// online_mean_covariance_tb: self-checking bench for the quality mean/covariance block
// depends on omc_pkg and the online_mean_covariance rtl; keeps its own fixed-point model
`timescale 1ns / 100ps

module online_mean_covariance_tb;

  localparam int MAXL = 256;
  localparam int TRI_N = MAXL * (MAXL + 1) / 2;
  localparam longint CM_TOP = 64'sd36028797018963967;
  localparam longint VAL_TOP = 64'sd549755813887;
  localparam int WDOG_LIMIT = 200000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_func = omc_pkg::FN_PUSH;
  logic [7:0]  in_quality = '0;
  logic        in_last_in_read = 1'b0;
  logic [7:0]  in_row = '0;
  logic [7:0]  in_col = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [39:0] out_value;
  logic [2:0]  out_status;
  logic        cfg_we = 1'b0;
  logic        cfg_index = omc_pkg::REG_OFFSET;
  logic [19:0] cfg_wdata = '0;

  online_mean_covariance dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // model state
  logic [23:0] avg_mem [MAXL];
  longint      comom_mem [TRI_N];
  int          dev_mem [MAXL];
  int          cur_pos, nreads, rlen;
  bit          len_bad;
  logic [7:0]  q_offset;
  logic [19:0] q_cap;

  logic [39:0] want_value [$];
  logic [2:0]  want_status [$];

  int  errors = 0, n_push = 0, n_query = 0, n_clear = 0, n_results = 0;
  bit  calm = 1'b0;
  int  hold_req = 0, hold_done = 0, hold_left = 0, stall_left = 0, rx_pick;
  int  idle_cycles = 0;

  function automatic int tri_idx(int r, int c);
    return r * (r + 1) / 2 + c;
  endfunction

  function automatic void wipe_stats();
    for (int i = 0; i < MAXL; i++) avg_mem[i] = '0;
    for (int i = 0; i < TRI_N; i++) comom_mem[i] = 0;
    cur_pos = 0;
    nreads = 0;
    rlen = 0;
    len_bad = 1'b0;
  endfunction

  function automatic logic [2:0] apply_push(logic [7:0] q, logic lst);
    longint q16, d, e, mag, stepv, p, add, acc;
    int i;
    i = cur_pos;
    q16 = longint'(q) << 16;
    if (len_bad) return omc_pkg::ST_LEN;
    if (i == 0 && nreads >= int'(q_cap)) return omc_pkg::ST_CAP;
    if (i >= MAXL || (rlen != 0 && (i >= rlen || (lst && i + 1 != rlen)))) begin
      len_bad = 1'b1;
      return omc_pkg::ST_LEN;
    end
    if (i == 0) nreads = (nreads + 1) & 20'hFFFFF;
    if (nreads == 0) return omc_pkg::ST_CAP;
    d = q16 - longint'(avg_mem[i]);
    dev_mem[i] = int'(d);
    mag = (d < 0 ? -d : d) / nreads;
    stepv = d < 0 ? -mag : mag;
    avg_mem[i] = 24'(longint'(avg_mem[i]) + stepv);
    e = q16 - longint'(avg_mem[i]);
    for (int j = 0; j <= i; j++) begin
      p = longint'(dev_mem[j]) * e;
      add = ((p < 0 ? -p : p) + 32768) >>> 16;
      if (p < 0) add = -add;
      acc = comom_mem[tri_idx(i, j)] + add;
      if (acc > CM_TOP) acc = CM_TOP;
      if (acc < -CM_TOP - 1) acc = -CM_TOP - 1;
      comom_mem[tri_idx(i, j)] = acc;
    end
    if (lst) begin
      if (rlen == 0) rlen = i + 1;
      cur_pos = 0;
    end else begin
      cur_pos = i + 1;
    end
    return omc_pkg::ST_OK;
  endfunction

  // expected answer for one request, updating the model state
  function automatic void predict_answer(logic [1:0] f, logic [7:0] q, logic lst,
                                         logic [7:0] r, logic [7:0] c,
                                         output logic [39:0] v, output logic [2:0] st);
    longint cm, m, res;
    v = '0;
    st = omc_pkg::ST_OK;
    if (f == omc_pkg::FN_PUSH) begin
      st = apply_push(q, lst);
    end else if (f == omc_pkg::FN_CLEAR) begin
      wipe_stats();
    end else if (len_bad) begin
      st = omc_pkg::ST_LEN;
    end else if (f == omc_pkg::FN_MEAN) begin
      if (rlen == 0 || nreads == 0) st = omc_pkg::ST_FEW;
      else if (int'(r) >= rlen) st = omc_pkg::ST_IDX;
      else v = 40'(longint'(avg_mem[r]) - (longint'(q_offset) << 16));
    end else begin
      if (nreads < 2 || rlen == 0) st = omc_pkg::ST_FEW;
      else if (int'(r) >= rlen || c > r) st = omc_pkg::ST_IDX;
      else begin
        cm = comom_mem[tri_idx(r, c)];
        m = (cm < 0 ? -cm : cm) / (nreads - 1);
        res = cm < 0 ? -m : m;
        if (res > VAL_TOP) res = VAL_TOP;
        if (res < -VAL_TOP - 1) res = -VAL_TOP - 1;
        v = 40'(res);
      end
    end
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic send_req(input logic [1:0] f, input logic [7:0] q, input logic lst,
                          input logic [7:0] r, input logic [7:0] c);
    int gap;
    logic [39:0] v;
    logic [2:0] st;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_quality <= q;
    in_last_in_read <= lst;
    in_row <= r;
    in_col <= c;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_answer(f, q, lst, r, c, v, st);
    want_value.push_back(v);
    want_status.push_back(st);
    if (f == omc_pkg::FN_PUSH) n_push++;
    else if (f == omc_pkg::FN_CLEAR) n_clear++;
    else n_query++;
  endtask

  task automatic push_q(input logic [7:0] q, input logic lst);
    send_req(omc_pkg::FN_PUSH, q, lst, 8'($urandom), 8'($urandom));
  endtask

  task automatic query(input logic [1:0] f, input logic [7:0] r, input logic [7:0] c);
    send_req(f, 8'($urandom), 1'($urandom), r, c);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (want_status.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic cfg_write(input logic idx, input logic [19:0] data);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == omc_pkg::REG_OFFSET) q_offset = data[7:0];
    else q_cap = data;
  endtask

  task automatic push_read(input int len, input int hi);
    for (int i = 0; i < len; i++) push_q(8'($urandom_range(0, hi)), i == len - 1);
  endtask

  task automatic test_empty_queries();
    query(omc_pkg::FN_MEAN, 0, 0);
    query(omc_pkg::FN_COV, 0, 0);
    push_q(8'd0, 1'b0);
    query(omc_pkg::FN_MEAN, 0, 0);
    push_q(8'd255, 1'b1);
    query(omc_pkg::FN_COV, 1, 0);
    query(omc_pkg::FN_MEAN, 1, 0);
  endtask

  task automatic test_basic_reads();
    send_req(omc_pkg::FN_CLEAR, 0, 0, 0, 0);
    push_q(8'd0, 1'b0); push_q(8'd255, 1'b0); push_q(8'd128, 1'b1);
    push_q(8'd255, 1'b0); push_q(8'd0, 1'b0);
    query(omc_pkg::FN_COV, 1, 0);
    push_q(8'd1, 1'b1);
    push_q(8'd37, 1'b0); push_q(8'd200, 1'b0); push_q(8'd90, 1'b1);
    for (int r = 0; r < 3; r++) begin
      query(omc_pkg::FN_MEAN, 8'(r), 0);
      for (int c = 0; c <= r; c++) query(omc_pkg::FN_COV, 8'(r), 8'(c));
    end
    query(omc_pkg::FN_MEAN, 3, 0);
    query(omc_pkg::FN_COV, 1, 2);
    query(omc_pkg::FN_COV, 255, 255);
  endtask

  task automatic test_length_fault();
    push_q(8'd10, 1'b0); push_q(8'd20, 1'b0); push_q(8'd30, 1'b0);
    query(omc_pkg::FN_MEAN, 0, 0);
    push_q(8'd40, 1'b1);
    send_req(omc_pkg::FN_CLEAR, 0, 0, 0, 0);
    push_read(3, 255);
    push_q(8'd5, 1'b1);
    query(omc_pkg::FN_COV, 0, 0);
    send_req(omc_pkg::FN_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_config_extremes();
    cfg_write(omc_pkg::REG_CAP, 20'd1);
    cfg_write(omc_pkg::REG_OFFSET, 20'd0);
    push_read(2, 255);
    push_q(8'd77, 1'b0);
    push_q(8'd78, 1'b1);
    query(omc_pkg::FN_MEAN, 1, 0);
    cfg_write(omc_pkg::REG_CAP, 20'hFFFFF);
    cfg_write(omc_pkg::REG_OFFSET, 20'd255);
    push_read(2, 255);
    query(omc_pkg::FN_MEAN, 0, 0);
    query(omc_pkg::FN_COV, 1, 1);
    cfg_write(omc_pkg::REG_CAP, 20'd3);
    push_read(2, 255);
    push_read(2, 255);
    query(omc_pkg::FN_COV, 1, 0);
  endtask

  task automatic test_full_length();
    send_req(omc_pkg::FN_CLEAR, 0, 0, 0, 0);
    cfg_write(omc_pkg::REG_CAP, 20'd100000);
    cfg_write(omc_pkg::REG_OFFSET, 20'd33);
    calm = 1'b1;
    push_read(MAXL, 255);
    push_read(MAXL, 255);
    calm = 1'b0;
    query(omc_pkg::FN_MEAN, 255, 0);
    query(omc_pkg::FN_COV, 255, 0);
    query(omc_pkg::FN_COV, 255, 255);
    send_req(omc_pkg::FN_CLEAR, 0, 0, 0, 0);
    // first read running past the largest length
    calm = 1'b1;
    for (int i = 0; i <= MAXL; i++) push_q(8'($urandom), 1'b0);
    calm = 1'b0;
    query(omc_pkg::FN_MEAN, 0, 0);
    send_req(omc_pkg::FN_CLEAR, 0, 0, 0, 0);
  endtask

  task automatic test_backpressure();
    drain();
    hold_req++;
    for (int i = 0; i < 16; i++) begin
      if (i % 4 == 3) query(omc_pkg::FN_MEAN, 8'($urandom_range(0, 3)), 0);
      else push_q(8'($urandom), cur_pos + 1 == rlen || (rlen == 0 && cur_pos == 3));
    end
    drain();
  endtask

  task automatic test_random_sessions();
    int len, r, budget;
    logic [7:0] row;
    for (int s = 0; s < 8; s++) begin
      cfg_write(omc_pkg::REG_OFFSET, 20'($urandom_range(0, 255)));
      r = $urandom_range(0, 3);
      cfg_write(omc_pkg::REG_CAP, r == 0 ? 20'($urandom_range(2, 6)) : 20'($urandom));
      send_req(omc_pkg::FN_CLEAR, 0, 0, 0, 0);
      len = $urandom_range(0, 9) == 0 ? $urandom_range(9, 20) : $urandom_range(1, 8);
      calm = (s % 3 == 1);
      budget = 37;
      for (int k = 0; k < budget; k++) begin
        r = $urandom_range(0, 99);
        if (r < 68) begin
          push_q(8'($urandom), cur_pos + 1 == len);
        end else if (r < 90) begin
          row = 8'($urandom_range(0, len));
          query($urandom_range(0, 2) == 0 ? omc_pkg::FN_MEAN : omc_pkg::FN_COV, row,
                8'($urandom_range(0, row)));
        end else if (r < 97) begin
          query($urandom_range(0, 1) ? omc_pkg::FN_MEAN : omc_pkg::FN_COV,
                8'($urandom), 8'($urandom));
        end else begin
          push_q(8'($urandom), 1'($urandom));
        end
      end
      if (s == 3) test_backpressure();
    end
    calm = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (want_status.size() == 0) begin
        $error("result with no request outstanding: value %h status %0d",
               out_value, out_status);
        errors++;
      end else begin
        if (out_value !== want_value[0]) begin
          $error("value: expected %h, got %h", want_value[0], out_value);
          errors++;
        end
        if (out_status !== want_status[0]) begin
          $error("status: expected %0d, got %0d", want_status[0], out_status);
          errors++;
        end
        void'(want_value.pop_front());
        void'(want_status.pop_front());
      end
    end
  end

  // result side: random stalls plus a requested long hold-off
  always @(posedge clk) begin
    rx_pick = $urandom_range(0, 99);
    if (hold_done != hold_req) begin
      hold_done <= hold_req;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (calm || rx_pick < 65) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= 1'b0;
      stall_left <= rx_pick < 95 ? $urandom_range(0, 2) : $urandom_range(5, 40);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WDOG_LIMIT) begin
      $display("timeout: no progress for %0d cycles", WDOG_LIMIT);
      $display("online_mean_covariance_tb NOT OK");
      $finish;
    end
  end

  initial begin
    q_offset = omc_pkg::OFFSET_RESET;
    q_cap = omc_pkg::CAP_RESET;
    for (int i = 0; i < MAXL; i++) dev_mem[i] = 0;
    wipe_stats();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_queries();
    test_basic_reads();
    test_length_fault();
    test_config_extremes();
    test_full_length();
    test_random_sessions();
    drain();
    $display("covered %0d pushes, %0d queries, %0d clears; %0d results checked",
             n_push, n_query, n_clear, n_results);
    $display("incl. cap drops, length faults, full-length reads and output hold-off");
    if (errors == 0) begin
      $display("online_mean_covariance_tb OK");
    end else begin
      $display("online_mean_covariance_tb NOT OK");
    end
    $finish;
  end

endmodule

### sim.f
design/omc_pkg.sv
design/omc_div.sv
design/online_mean_covariance.sv
tb/sv/online_mean_covariance_tb.sv
